// File: rtl/frrf_pkg.sv
// Shared types, constants and helpers for the free region run finder.
package frrf_pkg;

	localparam int DATA_W    = 32;
	localparam int SUM_W     = DATA_W + 1;
	localparam int CFG_IDX_W = 1;

	localparam logic [DATA_W-1:0] MIN_RUN_RESET   = 32'd4096;
	localparam logic [DATA_W-1:0] PART_SIZE_RESET = 32'd1048576;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_RUN_SIZE   = 1'b0,
		CFG_PARTITION_SIZE = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [DATA_W-1:0] run_offset;
		logic [DATA_W-1:0] run_size;
		logic              last;
	} res_t;

	// up to two results written into the queue in one cycle
	typedef struct packed {
		logic [1:0] n;
		res_t       res0;
		res_t       res1;
	} push_t;

	// clamp a 33 bit sum to 32 bits
	function automatic logic [DATA_W-1:0] sat32(input logic [SUM_W-1:0] v);
		return v[SUM_W-1] ? {DATA_W{1'b1}} : v[DATA_W-1:0];
	endfunction

endpackage

// File: rtl/frrf_scan.sv
// Scan state registers and the page / end marker update logic.
module frrf_scan import frrf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              kind,
	input  logic [DATA_W-1:0] pg_offset,
	input  logic [DATA_W-1:0] pg_length,
	input  logic              page_obsolete,
	input  logic [DATA_W-1:0] min_run_size,
	input  logic [DATA_W-1:0] partition_size,
	output push_t             push
);

	logic [DATA_W-1:0] scan_q;
	logic              open_q;
	logic [DATA_W-1:0] begin_q;
	logic [DATA_W-1:0] len_q;
	logic [SUM_W-1:0]  end_q;     // begin_q + len_q, valid while open
	logic              fin_q;

	logic [SUM_W-1:0]  pg_end;
	logic              r1, r2, open1, gap, gap_adj, skip, extend, ovf;
	logic [DATA_W-1:0] scan1, tgt, begin2, dist2, begin3, len3;
	logic [SUM_W-1:0]  diff3, end3;
	res_t              res_r2;

	logic [DATA_W-1:0] scan_d, begin_d, len_d;
	logic [SUM_W-1:0]  end_d;
	logic              open_d, fin_d;

	always_comb begin
		pg_end = {1'b0, pg_offset} + {1'b0, pg_length};

		// a run already long enough goes out first
		r1    = open_q && (len_q >= min_run_size);
		scan1 = r1 ? sat32(end_q) : scan_q;
		open1 = open_q && !r1;

		// free gap up to the page start, or up to the region end
		tgt     = kind ? partition_size : pg_offset;
		gap     = tgt > scan1;
		gap_adj = open1 && (end_q == {1'b0, scan1});
		begin2  = gap ? (gap_adj ? begin_q : scan1) : begin_q;
		dist2   = tgt - begin2;

		skip = !kind && (pg_end <= {1'b0, scan1});

		// obsolete page joins the run or starts a new one
		extend = gap || (open1 && (end_q == {1'b0, pg_offset}));
		begin3 = extend ? begin2 : pg_offset;
		diff3  = pg_end - {1'b0, begin3};
		ovf    = diff3[SUM_W-1];
		len3   = ovf ? {DATA_W{1'b1}} : diff3[DATA_W-1:0];
		end3   = ovf ? ({1'b0, begin3} + {1'b0, {DATA_W{1'b1}}}) : pg_end;

		if (!kind && !skip && page_obsolete) begin
			r2                = len3 >= min_run_size;
			res_r2.run_offset = begin3;
			res_r2.run_size   = len3;
		end else begin
			r2                = !skip && gap && (dist2 >= min_run_size);
			res_r2.run_offset = begin2;
			res_r2.run_size   = dist2;
		end
		res_r2.last = 1'b1;

		// next state
		scan_d  = scan_q;
		open_d  = open_q;
		begin_d = begin_q;
		len_d   = len_q;
		end_d   = end_q;
		fin_d   = fin_q;
		if (kind) begin
			fin_d = 1'b1;
		end else if (skip) begin
			scan_d = scan1;
			open_d = open1;
		end else begin
			scan_d = sat32(pg_end);
			open_d = page_obsolete && !r2;
			begin_d = begin3;
			len_d   = len3;
			end_d   = end3;
		end

		// results, the final one flagged last
		push.res0.run_offset = r1 ? begin_q : res_r2.run_offset;
		push.res0.run_size   = r1 ? len_q : res_r2.run_size;
		push.res0.last       = !(r1 && r2);
		push.res1            = res_r2;
		if (fire && !fin_q)
			push.n = {1'b0, r1} + {1'b0, r2};
		else
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			open_q  <= 1'b0;
			begin_q <= '0;
			len_q   <= '0;
			end_q   <= '0;
			fin_q   <= 1'b0;
		end else if (fire && !fin_q) begin
			scan_q  <= scan_d;
			open_q  <= open_d;
			begin_q <= begin_d;
			len_q   <= len_d;
			end_q   <= end_d;
			fin_q   <= fin_d;
		end
	end

endmodule

// File: rtl/frrf_res_fifo.sv
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ready is high.
module frrf_res_fifo import frrf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  res
);

	res_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign res       = mem_q[rd_ptr_q];
	assign wr_ptr1   = wr_ptr_q + PTR_W'(1);
	// two free slots, counting the one freed by this cycle's transfer
	assign room = (cnt_q <= CNT_W'(FIFO_DEPTH - 2)) ||
	              ((cnt_q == CNT_W'(FIFO_DEPTH - 1)) && pop);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_ptr_q] <= push.res0;
		if (push.n == 2'd2)
			mem_q[wr_ptr1] <= push.res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue count past depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("results pushed without room");

	a_push_n: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd3)
		else $error("more than two results from one item");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (!push.res0.last && push.res1.last))
		else $error("last flag misplaced on result pair");

endmodule

// File: rtl/free_region_run_finder_core.sv
// Top level of the free region run finder: config, input stage, scan, result queue.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  in       | in_valid / in_ready   | kind, pg_offset, pg_length, page_obsolete
//  out      | out_valid / out_ready | run_offset, run_size, last
//  cfg      | cfg_we                | cfg_index, cfg_wdata (0 min run, 1 partition)
//
// An input transfer is held in the input stage and handled by the scan logic
// once the result queue has room for two results, so items are taken back to
// back while it has room; the queue drains one result per cycle while
// out_ready is high. Reset clears the scan state, queue pointers and input
// stage and loads the register defaults. A stalled output holds off input
// once the queue cannot take two more results.
module free_region_run_finder_core import frrf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [DATA_W-1:0]    pg_offset,
	input  logic [DATA_W-1:0]    pg_length,
	input  logic                 page_obsolete,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    run_offset,
	output logic [DATA_W-1:0]    run_size,
	output logic                 last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata
);

	// configuration registers
	logic [DATA_W-1:0] min_run_q;
	logic [DATA_W-1:0] region_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_run_q     <= MIN_RUN_RESET;
			region_size_q <= PART_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_RUN_SIZE:   min_run_q     <= cfg_wdata;
				CFG_PARTITION_SIZE: region_size_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input stage
	logic              valid_s1;
	logic              kind_s1;
	logic [DATA_W-1:0] offset_s1;
	logic [DATA_W-1:0] size_s1;
	logic              obsolete_s1;
	logic              room;
	logic              fire;

	// the staged item is handled once the queue can hold both possible results
	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1     <= kind;
			offset_s1   <= pg_offset;
			size_s1     <= pg_length;
			obsolete_s1 <= page_obsolete;
		end
	end

	push_t push;
	res_t  res;

	frrf_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.kind           (kind_s1),
		.pg_offset      (offset_s1),
		.pg_length      (size_s1),
		.page_obsolete  (obsolete_s1),
		.min_run_size   (min_run_q),
		.partition_size (region_size_q),
		.push           (push)
	);

	frrf_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign run_offset = res.run_offset;
	assign run_size   = res.run_size;
	assign last       = res.last;

endmodule
